// ===== src/lbab_pkg.sv =====
// ----------------------------------------------------------------------------
// lbab_pkg
// Shared types and constants of the low-battery alarm buzzer.
// ----------------------------------------------------------------------------
package lbab_pkg;

  localparam int unsigned AVG_SAMPLES  = 8;
  localparam int unsigned ADC_BITS     = 12;
  localparam int unsigned AVG_CNT_W    = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int unsigned SUM_W        = ADC_BITS + AVG_CNT_W;
  localparam int unsigned MV_W         = 14;
  localparam int unsigned MV_SCALE_NUM = 2475;
  localparam int unsigned MV_SCALE_SH  = 10;
  localparam int unsigned SCALE_W      = 12;
  localparam int unsigned PROD_W       = ADC_BITS + SCALE_W;
  localparam int unsigned PADDR_W      = 5;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [MV_W-1:0]    MV_MAX        = '1;
  localparam logic [15:0]        LOW_COUNT_MAX = 16'hFFFF;
  localparam logic [SCALE_W-1:0] MV_SCALE      = SCALE_W'(MV_SCALE_NUM);

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } lbab_op_e;

  typedef enum logic [2:0] {
    REG_LOW_MV    = 3'd0,
    REG_LOW_MS    = 3'd1,
    REG_BEEP_ON   = 3'd2,
    REG_BEEP_PER  = 3'd3,
    REG_TONE_HALF = 3'd4,
    REG_TICKS_MS  = 3'd5
  } lbab_reg_e;

  typedef struct packed {
    lbab_op_e            operation;
    logic [ADC_BITS-1:0] adc_sample;
    logic                manual_hold;
    logic                beep_request;
  } lbab_req_t;

  typedef struct packed {
    logic            buzzer_out;
    logic [MV_W-1:0] battery_mv;
    logic            alarm_active;
  } lbab_rsp_t;

  typedef struct packed {
    logic [15:0] low_voltage_mv;
    logic [15:0] low_time_ms;
    logic [15:0] beep_on_ticks;
    logic [15:0] beep_period_ticks;
    logic [7:0]  tone_half_period;
    logic [7:0]  ticks_per_ms;
  } lbab_cfg_t;

  typedef struct packed {
    logic buzzer;
    logic alarm;
  } lbab_alm_t;

endpackage

// ===== src/lbab_regs.sv =====
// ----------------------------------------------------------------------------
// lbab_regs
// APB register file holding the alarm thresholds and timing settings.
// ----------------------------------------------------------------------------
module lbab_regs import lbab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output lbab_cfg_t          cfg_o
);

  lbab_cfg_t cfg_q;
  logic      wr_en;
  lbab_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = lbab_reg_e'(paddr[PADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_voltage_mv    <= 16'd6400;
      cfg_q.low_time_ms       <= 16'd5000;
      cfg_q.beep_on_ticks     <= 16'd5000;
      cfg_q.beep_period_ticks <= 16'd10000;
      cfg_q.tone_half_period  <= 8'd2;
      cfg_q.ticks_per_ms      <= 8'd10;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOW_MV:    cfg_q.low_voltage_mv    <= pwdata[15:0];
        REG_LOW_MS:    cfg_q.low_time_ms       <= pwdata[15:0];
        REG_BEEP_ON:   cfg_q.beep_on_ticks     <= pwdata[15:0];
        REG_BEEP_PER:  cfg_q.beep_period_ticks <= pwdata[15:0];
        REG_TONE_HALF: cfg_q.tone_half_period  <= pwdata[7:0];
        REG_TICKS_MS:  cfg_q.ticks_per_ms      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW_MV:    prdata = {16'd0, cfg_q.low_voltage_mv};
      REG_LOW_MS:    prdata = {16'd0, cfg_q.low_time_ms};
      REG_BEEP_ON:   prdata = {16'd0, cfg_q.beep_on_ticks};
      REG_BEEP_PER:  prdata = {16'd0, cfg_q.beep_period_ticks};
      REG_TONE_HALF: prdata = {24'd0, cfg_q.tone_half_period};
      REG_TICKS_MS:  prdata = {24'd0, cfg_q.ticks_per_ms};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== src/lbab_vmon.sv =====
// ----------------------------------------------------------------------------
// lbab_vmon
// Battery monitor: accumulates ADC samples and scales each average to mV.
// ----------------------------------------------------------------------------
module lbab_vmon import lbab_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [ADC_BITS-1:0] sample_i,
  output logic [MV_W-1:0] voltage_q_o,
  output logic [MV_W-1:0] voltage_d_o
);

  logic [SUM_W-1:0]     sum_q, sum_d, sum_inc;
  logic [AVG_CNT_W-1:0] cnt_q, cnt_d;
  logic [MV_W-1:0]      mv_q, mv_d;
  logic [ADC_BITS-1:0]  avg;
  logic [PROD_W-1:0]    prod, mv_full;
  logic                 last;

  assign sum_inc = sum_q + SUM_W'(sample_i);
  assign last    = (cnt_q == AVG_CNT_W'(AVG_SAMPLES - 1));
  assign avg     = ADC_BITS'(sum_inc / AVG_SAMPLES);
  assign prod    = PROD_W'(avg) * PROD_W'(MV_SCALE);
  assign mv_full = prod >> MV_SCALE_SH;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    mv_d  = mv_q;
    if (take_i) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
        mv_d  = (mv_full > PROD_W'(MV_MAX)) ? MV_MAX : mv_full[MV_W-1:0];
      end else begin
        sum_d = sum_inc;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      mv_q  <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      mv_q  <= mv_d;
    end
  end

  assign voltage_q_o = mv_q;
  assign voltage_d_o = mv_d;

endmodule

// ===== src/lbab_alarm.sv =====
// ----------------------------------------------------------------------------
// lbab_alarm
// Tone generator, beep cadence, millisecond prescaler and low-voltage timer.
// ----------------------------------------------------------------------------
module lbab_alarm import lbab_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  lbab_req_t       req_i,
  input  lbab_cfg_t       cfg_i,
  input  logic [MV_W-1:0] voltage_i,
  output lbab_alm_t       status_d_o
);

  logic [7:0]  tone_q, tone_d, tone_inc;
  logic        lvl_q, lvl_d;
  logic        gate_q, gate_d;
  logic [15:0] cad_q, cad_d, cad_inc;
  logic        alarm_q, alarm_d, alarm_req;
  logic [7:0]  pre_q, pre_d, pre_inc;
  logic [15:0] low_q, low_d, low_inc;

  assign alarm_req = alarm_q | req_i.beep_request;
  assign tone_inc  = tone_q + 8'd1;
  assign cad_inc   = cad_q + 16'd1;
  assign pre_inc   = pre_q + 8'd1;
  assign low_inc   = (low_q == LOW_COUNT_MAX) ? low_q : low_q + 16'd1;

  always_comb begin
    tone_d  = tone_q;
    lvl_d   = lvl_q;
    gate_d  = gate_q;
    cad_d   = cad_q;
    alarm_d = alarm_q;
    pre_d   = pre_q;
    low_d   = low_q;
    if (fire_i) begin
      alarm_d = alarm_req;
      if (req_i.operation == OP_TICK) begin
        if (gate_q) begin
          if (tone_inc >= cfg_i.tone_half_period) begin
            tone_d = '0;
            lvl_d  = ~lvl_q;
          end else begin
            tone_d = tone_inc;
          end
        end else begin
          lvl_d = 1'b0;
        end

        if (!alarm_req) begin
          gate_d = 1'b0;
          cad_d  = '0;
        end else if (cad_inc < cfg_i.beep_on_ticks) begin
          gate_d = 1'b1;
          cad_d  = cad_inc;
        end else if (cad_inc < cfg_i.beep_period_ticks) begin
          gate_d = 1'b0;
          cad_d  = cad_inc;
        end else begin
          cad_d  = '0;
        end

        if (pre_inc < cfg_i.ticks_per_ms) begin
          pre_d = pre_inc;
        end else begin
          pre_d = '0;
          if (16'(voltage_i) < cfg_i.low_voltage_mv) begin
            low_d = low_inc;
            if (low_inc > cfg_i.low_time_ms) begin
              alarm_d = 1'b1;
            end
          end else begin
            low_d = '0;
            if (!req_i.manual_hold) begin
              alarm_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q  <= '0;
      lvl_q   <= 1'b0;
      gate_q  <= 1'b0;
      cad_q   <= '0;
      alarm_q <= 1'b0;
      pre_q   <= '0;
      low_q   <= '0;
    end else begin
      tone_q  <= tone_d;
      lvl_q   <= lvl_d;
      gate_q  <= gate_d;
      cad_q   <= cad_d;
      alarm_q <= alarm_d;
      pre_q   <= pre_d;
      low_q   <= low_d;
    end
  end

  assign status_d_o.buzzer = lvl_d;
  assign status_d_o.alarm  = alarm_d;

endmodule

// ===== src/low_battery_alarm_buzzer_core.sv =====
// ----------------------------------------------------------------------------
// low_battery_alarm_buzzer_core
// Low-battery alarm: voltage averaging, low-time check and buzzer cadence.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, and its result is
// then captured in the result register.
// Throughput: one request per cycle; the input register stalls only while a
// result is held by a stalled output.
// Reset: all state and settings return to reset values and both pipeline valid
// flags clear; the request and result data registers are not reset.
module low_battery_alarm_buzzer_core import lbab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lbab_req_t          in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbab_rsp_t          out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic            in_vld_q, out_vld_q;
  lbab_req_t       req_q;
  lbab_rsp_t       rsp_q;
  logic            out_free, fire, in_take;
  lbab_cfg_t       cfg;
  lbab_alm_t       status_d;
  logic [MV_W-1:0] volt_q, volt_d;

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign fire       = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  lbab_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbab_vmon u_vmon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (fire & (req_q.operation == OP_SAMPLE)),
    .sample_i    (req_q.adc_sample),
    .voltage_q_o (volt_q),
    .voltage_d_o (volt_d)
  );

  lbab_alarm u_alarm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_i      (req_q),
    .cfg_i      (cfg),
    .voltage_i  (volt_q),
    .status_d_o (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q.buzzer_out   <= status_d.buzzer;
      rsp_q.battery_mv   <= volt_d;
      rsp_q.alarm_active <= status_d.alarm;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== src/lbab_checker.sv =====
// ----------------------------------------------------------------------------
// lbab_checker
// Port-level checks of the low-battery alarm buzzer, bound to the top level.
// ----------------------------------------------------------------------------
module lbab_checker import lbab_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input lbab_rsp_t out_rsp_o,
  input logic      pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  a_mv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.battery_mv <= MV_W'(9897))
    else $error("battery voltage out of range");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o && pready)
    else $error("busy during reset");

endmodule

bind low_battery_alarm_buzzer_core lbab_checker u_lbab_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for low_battery_alarm_buzzer_core. Requests (ticks and
// ADC samples) go in over a valid/stall channel; an in-bench predictor of the
// averaging, millisecond low-time check, alarm cadence and tone generator
// works out each response, and a checker compares every accepted response
// in order. Settings are rewritten over APB between idle phases.
// ----------------------------------------------------------------------------
module tb_top;
  import lbab_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 100000;
  localparam int unsigned HOLD_OFF_CYCLES = 40;
  localparam int unsigned PHASE_REQUESTS  = 50;
  localparam int unsigned LOW_RUN_TICKS   = 30;
  localparam logic [15:0] LOW_RUN_MS      = 16'd20;
  localparam logic [2:0]  REG_UNUSED      = 3'd6;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  lbab_req_t          in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  lbab_rsp_t          out_rsp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  low_battery_alarm_buzzer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state and settings
  lbab_cfg_t   alarm_cfg = '{16'd6400, 16'd5000, 16'd5000, 16'd10000, 8'd2, 8'd10};
  logic [7:0]  tone_cnt   = '0;
  logic        buzz_lvl   = 1'b0;
  logic        gate_on    = 1'b0;
  logic [15:0] cad_cnt    = '0;
  logic        alarm_lvl  = 1'b0;
  logic [7:0]  ms_cnt     = '0;
  logic [15:0] low_ms_cnt = '0;
  logic [13:0] batt_mv    = '0;
  logic [14:0] adc_sum    = '0;
  int unsigned adc_cnt    = 0;

  lbab_rsp_t   alarm_rsp_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned req_cnt      = 0;
  int unsigned sample_cnt   = 0;
  int unsigned tick_cnt     = 0;
  int unsigned rsp_cnt      = 0;
  int unsigned alarm_rsp    = 0;
  int unsigned buzz_rsp     = 0;
  int unsigned setting_cnt  = 0;
  int unsigned cycle_cnt    = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;
  bit          hold_off_req = 1'b0;

  function automatic lbab_rsp_t predict_alarm_rsp(lbab_req_t rq);
    lbab_rsp_t   rsp;
    logic [31:0] mv_wide;
    if (rq.beep_request) alarm_lvl = 1'b1;
    if (rq.operation == OP_TICK) begin
      if (gate_on) begin
        tone_cnt = tone_cnt + 8'd1;
        if (tone_cnt >= alarm_cfg.tone_half_period) begin
          tone_cnt = '0;
          buzz_lvl = ~buzz_lvl;
        end
      end else begin
        buzz_lvl = 1'b0;
      end
      if (!alarm_lvl) begin
        gate_on = 1'b0;
        cad_cnt = '0;
      end else begin
        cad_cnt = cad_cnt + 16'd1;
        if (cad_cnt < alarm_cfg.beep_on_ticks) gate_on = 1'b1;
        else if (cad_cnt < alarm_cfg.beep_period_ticks) gate_on = 1'b0;
        else cad_cnt = '0;
      end
      ms_cnt = ms_cnt + 8'd1;
      if (ms_cnt >= alarm_cfg.ticks_per_ms) begin
        ms_cnt = '0;
        if (16'(batt_mv) < alarm_cfg.low_voltage_mv) begin
          if (low_ms_cnt != LOW_COUNT_MAX) low_ms_cnt = low_ms_cnt + 16'd1;
          if (low_ms_cnt > alarm_cfg.low_time_ms) alarm_lvl = 1'b1;
        end else begin
          low_ms_cnt = '0;
          if (!rq.manual_hold) alarm_lvl = 1'b0;
        end
      end
    end else begin
      adc_sum = adc_sum + 15'(rq.adc_sample);
      adc_cnt++;
      if (adc_cnt >= AVG_SAMPLES) begin
        mv_wide = ((32'(adc_sum) / AVG_SAMPLES) * MV_SCALE_NUM) >> MV_SCALE_SH;
        batt_mv = (mv_wide > 32'(MV_MAX)) ? MV_MAX : mv_wide[13:0];
        adc_sum = '0;
        adc_cnt = 0;
      end
    end
    rsp.buzzer_out   = buzz_lvl;
    rsp.battery_mv   = batt_mv;
    rsp.alarm_active = alarm_lvl;
    return rsp;
  endfunction

  function automatic lbab_req_t make_req(lbab_op_e op, logic [11:0] smp, logic hold,
                                         logic beep);
    lbab_req_t rq;
    rq.operation    = op;
    rq.adc_sample   = smp;
    rq.manual_hold  = hold;
    rq.beep_request = beep;
    return rq;
  endfunction

  task automatic send_request(input lbab_req_t rq);
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    do @(posedge clk_i); while (in_stall_o);
    alarm_rsp_q.push_back(predict_alarm_rsp(rq));
    req_cnt++;
    if (rq.operation == OP_SAMPLE) sample_cnt++;
    else tick_cnt++;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (alarm_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOW_MV:    alarm_cfg.low_voltage_mv    = value;
      REG_LOW_MS:    alarm_cfg.low_time_ms       = value;
      REG_BEEP_ON:   alarm_cfg.beep_on_ticks     = value;
      REG_BEEP_PER:  alarm_cfg.beep_period_ticks = value;
      REG_TONE_HALF: alarm_cfg.tone_half_period  = value[7:0];
      REG_TICKS_MS:  alarm_cfg.ticks_per_ms      = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all_settings(input lbab_cfg_t c);
    cfg_write(REG_LOW_MV, c.low_voltage_mv);
    cfg_write(REG_LOW_MS, c.low_time_ms);
    cfg_write(REG_BEEP_ON, c.beep_on_ticks);
    cfg_write(REG_BEEP_PER, c.beep_period_ticks);
    cfg_write(REG_TONE_HALF, {8'($urandom), c.tone_half_period});
    cfg_write(REG_TICKS_MS, {8'($urandom), c.ticks_per_ms});
    setting_cnt++;
  endtask

  // Eight samples around one level, then a run of ticks
  task automatic run_battery_burst();
    logic [11:0] level;
    logic        hold;
    int          n_ticks;
    level   = 12'($urandom_range(0, 4095));
    hold    = 1'($urandom_range(0, 1));
    n_ticks = $urandom_range(2, 30);
    repeat (AVG_SAMPLES)
      send_request(make_req(OP_SAMPLE, level ^ 12'($urandom_range(0, 7)),
                            hold, 1'($urandom_range(0, 29) == 0)));
    repeat (n_ticks)
      send_request(make_req(OP_TICK, 12'($urandom), hold ^ ($urandom_range(0, 9) == 0),
                            1'($urandom_range(0, 29) == 0)));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_request(make_req(lbab_op_e'($urandom_range(0, 1)), 12'($urandom),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0)));
  endtask

  task automatic test_reset_defaults();
    repeat (AVG_SAMPLES) send_request(make_req(OP_SAMPLE, 12'hFFF, 1'b0, 1'b0));
    send_request(make_req(OP_SAMPLE, 12'hAAA, 1'b1, 1'b1));
    send_request(make_req(OP_SAMPLE, 12'h555, 1'b0, 1'b0));
    repeat (AVG_SAMPLES - 2) send_request(make_req(OP_SAMPLE, 12'h000, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 12'h000, 1'b1, 1'b1));
    send_request(make_req(OP_TICK, 12'hFFF, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 12'h000, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_zero_settings();
    cfg_write(REG_TICKS_MS, 16'd0);
    cfg_write(REG_TONE_HALF, 16'hFF00);
    cfg_write(REG_BEEP_ON, 16'd3);
    cfg_write(REG_BEEP_PER, 16'd0);
    cfg_write(REG_LOW_MS, 16'd0);
    cfg_write(REG_UNUSED, 16'hFFFF);
    setting_cnt++;
    send_request(make_req(OP_TICK, 12'h000, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 12'h000, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 12'hFFF, 1'b0, 1'b1));
    send_request(make_req(OP_TICK, 12'h000, 1'b1, 1'b0));
    send_request(make_req(OP_TICK, 12'h000, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    lbab_cfg_t   c;
    int unsigned start;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        c = '{16'd0, 16'd0, 16'd0, 16'd1, 8'd1, 8'd1};
      end else if (p == 1) begin
        c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
      end else begin
        c.low_voltage_mv    = 16'($urandom_range(0, 9897));
        c.low_time_ms       = 16'($urandom_range(0, 6));
        c.beep_on_ticks     = 16'($urandom_range(0, 12));
        c.beep_period_ticks = 16'($urandom_range(0, 20));
        c.tone_half_period  = 8'($urandom_range(0, 4));
        c.ticks_per_ms      = 8'($urandom_range(0, 4));
      end
      write_all_settings(c);
      rx_idle_en = (p != 3);
      start = req_cnt;
      while (req_cnt - start < PHASE_REQUESTS) begin
        if ($urandom_range(0, 4) != 0) run_battery_burst();
        else run_noise();
      end
      wait_drained();
    end
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    repeat (24)
      send_request(make_req(lbab_op_e'($urandom_range(0, 1)), 12'($urandom),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) == 0)));
    wait_drained();
  endtask

  task automatic test_low_time_threshold();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    cfg_write(REG_LOW_MV, 16'd0);
    cfg_write(REG_TICKS_MS, 16'd1);
    send_request(make_req(OP_TICK, 12'h000, 1'b0, 1'b0));
    wait_drained();
    cfg_write(REG_LOW_MV, 16'hFFFF);
    cfg_write(REG_LOW_MS, LOW_RUN_MS);
    setting_cnt++;
    repeat (LOW_RUN_TICKS)
      send_request(make_req(OP_TICK, 12'($urandom), 1'($urandom_range(0, 1)), 1'b0));
    wait_drained();
    cfg_write(REG_LOW_MS, 16'hFFFF);
    setting_cnt++;
    repeat (4) send_request(make_req(OP_TICK, 12'($urandom), 1'($urandom_range(0, 1)), 1'b0));
    wait_drained();
  endtask

  initial begin
    int burst_left;
    burst_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(0, 8);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    lbab_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alarm_rsp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("response with none outstanding: buzzer %0b mv %0d alarm %0b",
                   out_rsp_o.buzzer_out, out_rsp_o.battery_mv, out_rsp_o.alarm_active);
      end else begin
        want = alarm_rsp_q.pop_front();
        rsp_cnt++;
        if (want.alarm_active) alarm_rsp++;
        if (want.buzzer_out) buzz_rsp++;
        if (out_rsp_o.buzzer_out !== want.buzzer_out ||
            out_rsp_o.battery_mv !== want.battery_mv ||
            out_rsp_o.alarm_active !== want.alarm_active) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch on response %0d: buzzer %0b/%0b mv %0d/%0d alarm %0b/%0b",
                     rsp_cnt, want.buzzer_out, out_rsp_o.buzzer_out, want.battery_mv,
                     out_rsp_o.battery_mv, want.alarm_active, out_rsp_o.alarm_active);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("low_battery_alarm_buzzer_core verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_settings();
    test_random_traffic();
    test_backpressure();
    test_low_time_threshold();

    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests (%0d samples, %0d ticks) across %0d register settings",
             req_cnt, sample_cnt, tick_cnt, setting_cnt);
    $display("Checked %0d responses: %0d with alarm raised, %0d with buzzer high",
             rsp_cnt, alarm_rsp, buzz_rsp);
    if (mismatch_cnt == 0 && alarm_rsp_q.size() == 0) begin
      $display("low_battery_alarm_buzzer_core verification clean");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_cnt, alarm_rsp_q.size());
      $display("low_battery_alarm_buzzer_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lbab_pkg.sv
src/lbab_regs.sv
src/lbab_vmon.sv
src/lbab_alarm.sv
src/low_battery_alarm_buzzer_core.sv
src/lbab_checker.sv
bench/tb_top.sv
